FILE: rtl/core/ftrtc_pkg.sv
// Package for the fractional-tick real time clock with button adjustment.
// Holds payload structs, sequencer states, step codes and clock constants.
// No dependencies; every other file in rtl/core imports it.
package ftrtc_pkg;

    // Field widths of the time-of-day counters and the fraction accumulator.
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ACC_W   = 16;
    localparam int INC_W   = 15;
    localparam int PRESS_W = 7;
    localparam int CFG_W   = 16;

    // Clock constants.
    localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd20;
    localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
    localparam logic [MIN_W:0]    MIN_PER_HR = 7'd60;
    localparam logic [MIN_W:0]    UP_STEP    = 7'd5;
    localparam logic [MIN_W-1:0]  DOWN_STEP  = 6'd4;

    // Configuration register reset values.
    localparam logic [INC_W-1:0] TICK_INC_RESET = 15'd5100;
    localparam logic [ACC_W-1:0] SEC_MOD_RESET  = 16'd24942;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TICK_INCREMENT = 1'b0,
        CFG_SECOND_MODULUS = 1'b1
    } t_cfg_idx;

    // Input request payload.
    typedef struct packed {
        logic [PRESS_W-1:0] up_presses;
        logic [PRESS_W-1:0] down_presses;
    } t_in;

    // Result payload.
    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              display_update;
    } t_out;

    // Operations of the shared time step unit.
    typedef enum logic [1:0] {
        OP_ADJ_UP   = 2'd0,
        OP_ADJ_DOWN = 2'd1,
        OP_SEC_TICK = 2'd2
    } t_step_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_ADJ  = 3'd1,
        S_ACC  = 3'd2,
        S_SEC  = 3'd3,
        S_DONE = 3'd4
    } t_state;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic     accept;
        logic     adjust;
        logic     step_en;
        t_step_op op;
        logic     acc_add;
        logic     sec_chk;
        logic     out_load;
    } t_ctrl;

endpackage

FILE: rtl/core/fractional_tick_rtc_with_adjust.sv
// Top level of the fractional-tick real time clock with button adjustment.
// Holds configuration, time and accumulator registers and the result
// register; uses ftrtc_pkg, ftrtc_ctrl and ftrtc_step_unit.
//
//   Channel   Signals                              Direction
//   input     i_in_valid, o_in_stall, i_in_data    request in
//   output    o_out_valid, i_out_stall, o_out_data result out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data      register write
//
// An adjusting request steps once per net press through the shared step
// unit, any other request adds to the accumulator; both then check the
// second and wait for the result register to free up.
// Synchronous active-low reset returns the clock to 20:00:00 with an empty
// accumulator and the reset configuration.
// The result register lets a new request enter while a result is stalled.
module fractional_tick_rtc_with_adjust (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ftrtc_pkg::t_in               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ftrtc_pkg::t_out              o_out_data,
    input  logic                         i_cfg_we,
    input  ftrtc_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [ftrtc_pkg::CFG_W-1:0]  i_cfg_data
);
    import ftrtc_pkg::*;

    logic [INC_W-1:0]  r_tick_inc;
    logic [ACC_W-1:0]  r_sec_mod;
    logic [HOUR_W-1:0] r_hours;
    logic [MIN_W-1:0]  r_minutes;
    logic [SEC_W-1:0]  r_seconds;
    logic [ACC_W-1:0]  r_acc;
    logic              r_show;
    logic              r_out_valid;
    t_out              r_out;

    t_ctrl             ctrl;
    logic              sec_due;
    logic              out_free;
    logic [HOUR_W-1:0] step_hours;
    logic [MIN_W-1:0]  step_minutes;
    logic [SEC_W-1:0]  step_seconds;

    assign sec_due  = (r_acc >= r_sec_mod);
    assign out_free = !r_out_valid || !i_out_stall;

    ftrtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_sec_due  (sec_due),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    ftrtc_step_unit u_step (
        .i_op      (ctrl.op),
        .i_hours   (r_hours),
        .i_minutes (r_minutes),
        .i_seconds (r_seconds),
        .o_hours   (step_hours),
        .o_minutes (step_minutes),
        .o_seconds (step_seconds)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc <= TICK_INC_RESET;
            r_sec_mod  <= SEC_MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_INCREMENT: r_tick_inc <= i_cfg_data[INC_W-1:0];
                CFG_SECOND_MODULUS: r_sec_mod  <= i_cfg_data[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    // Time counters, fraction accumulator and display flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= HOUR_RESET;
            r_minutes <= '0;
            r_seconds <= '0;
            r_acc     <= '0;
            r_show    <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                r_show <= ctrl.adjust;
            end
            if (ctrl.adjust) begin
                r_seconds <= '0;
                r_acc     <= '0;
            end
            if (ctrl.acc_add) begin
                r_acc <= r_acc + {1'b0, r_tick_inc};
            end
            if (ctrl.sec_chk && sec_due) begin
                r_acc  <= r_acc - r_sec_mod;
                r_show <= 1'b1;
            end
            if (ctrl.step_en) begin
                r_hours   <= step_hours;
                r_minutes <= step_minutes;
                r_seconds <= step_seconds;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out.hours          <= r_hours;
            r_out.minutes        <= r_minutes;
            r_out.seconds        <= r_seconds;
            r_out.display_update <= r_show;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The result register is never overwritten while it holds a stalled result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> out_free)
        else $error("result register overwritten while stalled");

    // The time of day stays within its legal range.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hours <= HOUR_LAST) && (r_minutes <= MIN_LAST) && (r_seconds <= SEC_LAST))
        else $error("time counter out of range");

    // An adjusting request clears seconds and the fraction accumulator.
    a_adjust_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.adjust |=> (r_seconds == '0) && (r_acc == '0) && r_show)
        else $error("adjust did not clear seconds and accumulator");

    // A new request is taken only while no result is pending in the sequencer.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |=> !ctrl.accept)
        else $error("back-to-back requests accepted");

endmodule

FILE: rtl/core/ftrtc_step_unit.sv
// Shared time step unit: one adjust-up, adjust-down or one-second step on
// the hour, minute and second counters. Purely combinational; uses ftrtc_pkg.
module ftrtc_step_unit (
    input  ftrtc_pkg::t_step_op                 i_op,
    input  logic [ftrtc_pkg::HOUR_W-1:0]        i_hours,
    input  logic [ftrtc_pkg::MIN_W-1:0]         i_minutes,
    input  logic [ftrtc_pkg::SEC_W-1:0]         i_seconds,
    output logic [ftrtc_pkg::HOUR_W-1:0]        o_hours,
    output logic [ftrtc_pkg::MIN_W-1:0]         o_minutes,
    output logic [ftrtc_pkg::SEC_W-1:0]         o_seconds
);
    import ftrtc_pkg::*;

    logic [MIN_W:0]    min_up;
    logic [HOUR_W-1:0] hour_fwd;
    logic [HOUR_W-1:0] hour_back;

    // Hour neighbors with wrap around midnight.
    assign hour_fwd  = (i_hours == HOUR_LAST) ? '0 : i_hours + 5'd1;
    assign hour_back = (i_hours == '0) ? HOUR_LAST : i_hours - 5'd1;
    assign min_up    = {1'b0, i_minutes} + UP_STEP;

    // One step of the selected operation.
    always_comb begin
        o_hours   = i_hours;
        o_minutes = i_minutes;
        o_seconds = i_seconds;
        unique case (i_op)
            OP_ADJ_UP: begin
                if (min_up >= MIN_PER_HR) begin
                    o_minutes = MIN_W'(min_up - MIN_PER_HR);
                    o_hours   = hour_fwd;
                end else begin
                    o_minutes = min_up[MIN_W-1:0];
                end
            end
            OP_ADJ_DOWN: begin
                if (i_minutes < DOWN_STEP) begin
                    o_minutes = MIN_W'(MIN_PER_HR - {1'b0, DOWN_STEP} + {1'b0, i_minutes});
                    o_hours   = hour_back;
                end else begin
                    o_minutes = i_minutes - DOWN_STEP;
                end
            end
            OP_SEC_TICK: begin
                if (i_seconds == SEC_LAST) begin
                    o_seconds = '0;
                    if (i_minutes == MIN_LAST) begin
                        o_minutes = '0;
                        o_hours   = hour_fwd;
                    end else begin
                        o_minutes = i_minutes + 6'd1;
                    end
                end else begin
                    o_seconds = i_seconds + 6'd1;
                end
            end
            default: begin
                o_hours   = i_hours;
                o_minutes = i_minutes;
                o_seconds = i_seconds;
            end
        endcase
    end

endmodule

FILE: rtl/core/ftrtc_ctrl.sv
// Sequencer of the clock: accepts a request, runs adjust steps one net press
// at a time or the accumulator add, then the second check. Uses ftrtc_pkg.
module ftrtc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ftrtc_pkg::t_in        i_in_data,
    input  logic                  i_sec_due,
    input  logic                  i_out_free,
    output logic                  o_in_stall,
    output ftrtc_pkg::t_ctrl      o_ctrl
);
    import ftrtc_pkg::*;

    t_state             r_state, n_state;
    logic [PRESS_W-1:0] r_cnt, n_cnt;
    logic               r_dir_up, n_dir_up;
    logic               accept;
    logic               differ;
    logic               up_gt;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign differ = (i_in_data.up_presses != i_in_data.down_presses);
    assign up_gt  = (i_in_data.up_presses > i_in_data.down_presses);

    // Next state, step counter and direction.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dir_up = r_dir_up;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_dir_up = up_gt;
                    n_cnt    = up_gt
                             ? i_in_data.up_presses - i_in_data.down_presses
                             : i_in_data.down_presses - i_in_data.up_presses;
                    n_state  = differ ? S_ADJ : S_ACC;
                end
            end
            S_ADJ: begin
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_SEC;
                end
            end
            S_ACC:  n_state = S_SEC;
            S_SEC:  n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs decoded from the current state.
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.op       = OP_SEC_TICK;
        o_ctrl.accept   = accept;
        o_ctrl.adjust   = accept && differ;
        o_in_stall      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: ;
            S_ADJ: begin
                o_ctrl.step_en = 1'b1;
                o_ctrl.op      = r_dir_up ? OP_ADJ_UP : OP_ADJ_DOWN;
            end
            S_ACC:  o_ctrl.acc_add = 1'b1;
            S_SEC: begin
                o_ctrl.sec_chk = 1'b1;
                o_ctrl.step_en = i_sec_due;
            end
            S_DONE: o_ctrl.out_load = i_out_free;
            default: ;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_dir_up <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_dir_up <= n_dir_up;
        end
    end

endmodule
